// ----- hw/rtl/csrmv_pkg.sv -----
// Types, codes and default sizes shared by the sparse matrix-vector multiply block.
package csrmv_pkg;

   localparam int VECTOR_DEPTH_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT     = 65536;
   localparam int TASK_QUEUE_DEPTH     = 4;
   localparam int RESULT_QUEUE_DEPTH   = 4;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_NONZERO = 2'd1;
   localparam logic [1:0] FUNC_ROW_END = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         func;
      logic [9:0]         index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [15:0]        row_index;
      logic signed [63:0] row_sum;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value;
      logic signed [31:0] element;
   } task_type;

endpackage

// ----- hw/rtl/csrmv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module csrmv_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024,
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/csrmv_queue.sv -----
// Small register-based FIFO with an occupancy count.
module csrmv_queue #(
   parameter int Width = 8,
   parameter int Depth = 4,
   localparam int CountWidth = $clog2(Depth + 1),
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [Width-1:0]      wr_data,
   input  logic                  pop,
   output logic [Width-1:0]      rd_data,
   output logic [CountWidth-1:0] count
);

   logic [Width-1:0]      mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign count   = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CountWidth'(Depth)) |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("queue read while empty");
`endif

endmodule

// ----- hw/rtl/csrmv_front.sv -----
// Front end: accepts words, classifies them, loads and reads the vector store.
module csrmv_front import csrmv_pkg::*; #(
   parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEFAULT,
   localparam int CountWidth  = $clog2(TASK_QUEUE_DEPTH + 1),
   localparam int AddrWidth   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   input  logic [CountWidth-1:0] task_count,
   output logic                  task_push,
   output task_type              task_data
);

   logic        accept;
   logic        hit;
   logic [31:0] ram_rd_data;

   logic        f_valid_ff, f_valid_in;
   logic [1:0]  f_func_ff;
   logic signed [31:0] f_value_ff;
   logic        f_hit_ff;

   assign full   = (task_count + CountWidth'(f_valid_ff)) >= CountWidth'(TASK_QUEUE_DEPTH);
   assign accept = push && !full;
   assign hit    = 17'(req_data.index) < 17'(VECTOR_DEPTH);

   assign f_valid_in = accept && (req_data.func != FUNC_UNUSED);

   csrmv_ram #(
      .Width (32),
      .Depth (VECTOR_DEPTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (accept && (req_data.func == FUNC_LOAD) && hit),
      .wr_addr (AddrWidth'(req_data.index)),
      .wr_data (req_data.value),
      .rd_en   (accept && (req_data.func == FUNC_NONZERO)),
      .rd_addr (AddrWidth'(req_data.index)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_func_ff  <= req_data.func;
         f_value_ff <= req_data.value;
         f_hit_ff   <= hit;
      end
   end

   always_comb begin
      task_push         = f_valid_ff;
      task_data.func    = f_func_ff;
      task_data.value   = f_value_ff;
      task_data.element = (f_func_ff == FUNC_NONZERO && f_hit_ff) ? ram_rd_data : '0;
   end

endmodule

// ----- hw/rtl/csrmv_back.sv -----
// Back end: multiplies, accumulates with saturation and emits finished rows.
module csrmv_back import csrmv_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   localparam int CountWidth = $clog2(RESULT_QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  task_empty,
   input  task_type              task_data,
   output logic                  task_pop,
   input  logic [CountWidth-1:0] rsp_count,
   output logic                  rsp_push,
   output rsp_type               rsp_data
);

   logic               b_valid_ff;
   logic [1:0]         b_func_ff;
   logic signed [63:0] b_prod_ff, b_prod_in;

   logic signed [63:0] acc_ff, acc_in;
   logic [15:0]        row_ff, row_in;
   logic signed [63:0] sum;
   logic               overflow;

   assign task_pop  = !task_empty &&
      ((rsp_count + CountWidth'(b_valid_ff)) < CountWidth'(RESULT_QUEUE_DEPTH));
   assign b_prod_in = task_data.value * task_data.element;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= task_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (task_pop) begin
         b_func_ff <= task_data.func;
         b_prod_ff <= b_prod_in;
      end
   end

   assign sum      = acc_ff + b_prod_ff;
   assign overflow = (acc_ff[63] == b_prod_ff[63]) && (sum[63] != acc_ff[63]);

   always_comb begin
      acc_in             = acc_ff;
      row_in             = row_ff;
      rsp_push           = 1'b0;
      rsp_data.row_index = row_ff;
      rsp_data.row_sum   = acc_ff;
      if (b_valid_ff) begin
         case (b_func_ff)
            FUNC_LOAD: begin
               acc_in = '0;
               row_in = '0;
            end
            FUNC_NONZERO: begin
               acc_in = overflow ? (acc_ff[63] ? SUM_MIN : SUM_MAX) : sum;
            end
            FUNC_ROW_END: begin
               rsp_push = 1'b1;
               acc_in   = '0;
               row_in   = (row_ff == 16'(MAX_ROWS - 1)) ? '0 : row_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         row_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         row_ff <= row_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_func_ff == FUNC_LOAD) |=> (acc_ff == '0 && row_ff == '0))
      else $error("load did not clear row state");
   a_row_end_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (acc_ff == '0 &&
         (row_ff == $past(row_ff) + 1'b1 || row_ff == '0)))
      else $error("row end did not advance row state");
`endif

endmodule

// ----- hw/rtl/csr_sparse_matrix_vector_multiply_top.sv -----
// Top level of the CSR sparse matrix times dense vector block.
//
// Input words enter through push/full: a word is taken at a clock edge with
// push high and full low. func 0 loads one vector element and starts a new
// matrix, func 1 adds value times the stored element at the column index to
// the row sum, func 2 closes the row and emits one result word, func 3 is
// dropped. Results leave through empty/pop: the oldest result sits on rsp_data
// while empty is low and is taken at an edge with pop high.
// Throughput is one input word per cycle while full is low, set by the single
// 64-bit saturating add in the accumulator loop. A row-end word passes the
// vector store read, the task queue and the multiplier register in that order.
// A four-word task queue separates the store front end from the multiply back
// end, and a four-word result queue holds rows while the receiver stalls;
// when it fills, the back end holds and then full rises at the input.
// Synchronous reset empties both queues and clears the row sum and row count.
// The vector store is not cleared: load each element before it is used.
module csr_sparse_matrix_vector_multiply_top import csrmv_pkg::*; #(
   parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEFAULT,
   parameter int MAX_ROWS     = MAX_ROWS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int TaskCountWidth = $clog2(TASK_QUEUE_DEPTH + 1);
   localparam int RspCountWidth  = $clog2(RESULT_QUEUE_DEPTH + 1);

   logic                      task_push;
   logic                      task_pop;
   task_type                  task_wr_data;
   logic [$bits(task_type)-1:0] task_rd_bits;
   logic [TaskCountWidth-1:0] task_count;

   logic                      rsp_push;
   rsp_type                   rsp_wr_data;
   logic [$bits(rsp_type)-1:0] rsp_rd_bits;
   logic [RspCountWidth-1:0]  rsp_count;

   csrmv_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .task_count (task_count),
      .task_push  (task_push),
      .task_data  (task_wr_data)
   );

   csrmv_queue #(
      .Width ($bits(task_type)),
      .Depth (TASK_QUEUE_DEPTH)
   ) u_task_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (task_push),
      .wr_data (task_wr_data),
      .pop     (task_pop),
      .rd_data (task_rd_bits),
      .count   (task_count)
   );

   csrmv_back #(
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .task_empty (task_count == '0),
      .task_data  (task_type'(task_rd_bits)),
      .task_pop   (task_pop),
      .rsp_count  (rsp_count),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_wr_data)
   );

   csrmv_queue #(
      .Width ($bits(rsp_type)),
      .Depth (RESULT_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr_data),
      .pop     (pop && !empty),
      .rd_data (rsp_rd_bits),
      .count   (rsp_count)
   );

   assign empty    = (rsp_count == '0);
   assign rsp_data = rsp_type'(rsp_rd_bits);

endmodule

// ----- test/csrmv_checker.sv -----
// Checker that predicts row results of the sparse matrix-vector multiply block and compares them.
module csrmv_checker import csrmv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [31:0] element_mem [VECTOR_DEPTH_DEFAULT];
   logic signed [63:0] row_sum_acc;
   logic [15:0]        row_count;
   rsp_type            row_results_due [$];

   initial begin
      fail_count = 0;
      pending = 0;
      row_sum_acc = '0;
      row_count = '0;
   end

   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void accumulate_word(input req_type w);
      logic signed [63:0] factor_a;
      logic signed [63:0] factor_b;
      logic signed [63:0] product;
      logic signed [63:0] total;
      rsp_type            row_done;
      case (w.func)
         FUNC_LOAD: begin
            element_mem[w.index] = w.value;
            row_sum_acc = '0;
            row_count = '0;
         end
         FUNC_NONZERO: begin
            factor_a = w.value;
            factor_b = element_mem[w.index];
            product = factor_a * factor_b;
            total = row_sum_acc + product;
            if (row_sum_acc[63] == product[63] && total[63] != row_sum_acc[63]) begin
               total = row_sum_acc[63] ? SUM_MIN : SUM_MAX;
            end
            row_sum_acc = total;
         end
         FUNC_ROW_END: begin
            row_done.row_index = row_count;
            row_done.row_sum = row_sum_acc;
            row_results_due.push_back(row_done);
            row_sum_acc = '0;
            row_count = row_count + 16'd1;
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         row_sum_acc = '0;
         row_count = '0;
         row_results_due.delete();
      end else begin
         if (pop && !empty) begin
            if (row_results_due.size() == 0) begin
               report_failure($sformatf("row word with none pending: row %0d sum %h",
                                        rsp_data.row_index, rsp_data.row_sum));
            end else begin
               want = row_results_due.pop_front();
               if (rsp_data.row_index !== want.row_index) begin
                  report_failure($sformatf("row_index mismatch: got %0d, expected %0d",
                                           rsp_data.row_index, want.row_index));
               end
               if (rsp_data.row_sum !== want.row_sum) begin
                  report_failure($sformatf("row_sum mismatch on row %0d: got %h, expected %h",
                                           want.row_index, rsp_data.row_sum, want.row_sum));
               end
            end
         end
         if (push && !full) begin
            accumulate_word(req_data);
         end
      end
      pending = row_results_due.size();
   end

endmodule

// ----- test/csr_sparse_matrix_vector_multiply_top_tb.sv -----
// Testbench top for the sparse matrix-vector multiply block: stimulus, flow control and verdict.
module csr_sparse_matrix_vector_multiply_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csrmv_pkg::*;

   localparam int ITEM_TARGET  = 950;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int hold_request = 0;
   int items_sent = 0;
   bit quiet = 1'b0;
   bit col_loaded [VECTOR_DEPTH_DEFAULT];
   logic [9:0] loaded_cols [$];

   csr_sparse_matrix_vector_multiply_top dut (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data
   );

   csrmv_checker row_check (
      .clock, .reset, .push, .full, .req_data, .empty, .pop, .rsp_data,
      .fail_count, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            pop <= quiet || $urandom_range(99) >= 27;
         end
      end
   end

   task automatic send_word(input logic [1:0] fn, input logic [9:0] col,
                            input logic signed [31:0] val);
      req_type w;
      w.func = fn;
      w.index = col;
      w.value = val;
      while (!quiet && $urandom_range(99) < 27) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (full);
      @(negedge clock);
      if (fn == FUNC_LOAD && !col_loaded[col]) begin
         col_loaded[col] = 1'b1;
         loaded_cols.push_back(col);
      end
      if (fn != FUNC_UNUSED) begin
         items_sent++;
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return 32'(int'($urandom_range(131071)) - 65536);
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] pick_col();
      return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
   endfunction

   task automatic send_matrix();
      int n_rows;
      int n_nz;
      repeat ($urandom_range(6, 1)) send_word(FUNC_LOAD, 10'($urandom), pick_value());
      n_rows = $urandom_range(8, 1);
      repeat (n_rows) begin
         n_nz = $urandom_range(6);
         repeat (n_nz) send_word(FUNC_NONZERO, pick_col(), pick_value());
         send_word(FUNC_ROW_END, 10'($urandom), 32'($urandom));
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(3))
         0: send_word(FUNC_UNUSED, 10'($urandom), 32'($urandom));
         1: send_word(FUNC_ROW_END, 10'($urandom), 32'($urandom));
         2: begin
            repeat ($urandom_range(3, 1)) send_word(FUNC_NONZERO, pick_col(), pick_value());
            send_word(FUNC_LOAD, 10'($urandom), pick_value());
         end
         default: send_word(FUNC_NONZERO, pick_col(), pick_value());
      endcase
   endtask

   initial begin : stimulus
      bit held;
      bit paused;
      held = 1'b0;
      paused = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(FUNC_LOAD, 10'd0, 32'sh8000_0000);
      send_word(FUNC_LOAD, 10'd1023, 32'sh7FFF_FFFF);
      send_word(FUNC_LOAD, 10'd1, 32'shFFFF_FFFF);
      send_word(FUNC_LOAD, 10'h2AA, 32'sh0001_0000);
      send_word(FUNC_LOAD, 10'h155, 32'sh5555_AAAA);
      send_word(FUNC_ROW_END, 10'h3FF, 32'shFFFF_FFFF);
      send_word(FUNC_NONZERO, 10'd0, 32'sh8000_0000);
      send_word(FUNC_NONZERO, 10'd0, 32'sh8000_0000);
      send_word(FUNC_ROW_END, 10'd0, 32'sh0);
      send_word(FUNC_NONZERO, 10'd0, 32'sh8000_0000);
      send_word(FUNC_NONZERO, 10'd0, 32'sh8000_0000);
      send_word(FUNC_NONZERO, 10'd0, 32'sh7FFF_FFFF);
      send_word(FUNC_ROW_END, 10'h155, 32'sh5555_AAAA);
      send_word(FUNC_NONZERO, 10'd0, 32'sh7FFF_FFFF);
      send_word(FUNC_NONZERO, 10'd0, 32'sh7FFF_FFFF);
      send_word(FUNC_NONZERO, 10'd0, 32'sh7FFF_FFFF);
      send_word(FUNC_ROW_END, 10'h2AA, 32'shAAAA_5555);
      send_word(FUNC_NONZERO, 10'h2AA, 32'sh0001_0000);
      send_word(FUNC_NONZERO, 10'h155, 32'shAAAA_5555);
      send_word(FUNC_NONZERO, 10'd1, 32'shFFFF_FFFF);
      send_word(FUNC_ROW_END, 10'd1023, 32'sh7FFF_FFFF);
      send_word(FUNC_UNUSED, 10'h3FF, 32'shFFFF_FFFF);
      send_word(FUNC_NONZERO, 10'd1023, 32'sh7FFF_FFFF);
      send_word(FUNC_LOAD, 10'h155, 32'sh8000_0001);
      send_word(FUNC_ROW_END, 10'd0, 32'sh0);

      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent > 100) begin
            held = 1'b1;
            hold_request = HOLD_CYCLES;
            repeat (30) send_word(FUNC_ROW_END, 10'($urandom), 32'($urandom));
         end
         if (!paused && items_sent > 300) begin
            paused = 1'b1;
            push <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         quiet = items_sent >= 500 && items_sent < 700;
         if ($urandom_range(9) == 0) begin
            send_noise();
         end else begin
            send_matrix();
         end
      end
      quiet = 1'b0;

      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
